// ===== sv/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// shared widths, types and constants of the ray against box test
// ----------------------------------------------------------------------------
package rbi_pkg;

  localparam int CW      = 32;            // coordinate width, Q16.16
  localparam int FRAC    = 16;            // fraction bits
  localparam int QW      = CW + FRAC;     // quotient width
  localparam int THR_W   = 17;            // threshold register width
  localparam int DIST_W  = 31;            // distance result width
  localparam int LSPLIT  = 32;            // low part of lambda per multiplier
  localparam int LHW     = QW - LSPLIT;   // high part of lambda
  localparam int PROD_W  = QW + CW;       // full lambda times direction
  localparam int MW      = 2 * CW - 1;    // clamped offset magnitude
  localparam int PXW     = MW + 2;        // hit point width
  localparam int NFACE   = 6;

  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(66);
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [MW-1:0]     OFF_SAT   = MW'(1) << (MW - 1);

  typedef logic [2:0][CW-1:0] vec3_t;

  typedef struct packed {
    vec3_t            o;
    vec3_t            d;
    vec3_t            lo;
    vec3_t            hi;
    vec3_t            dmag;
    logic [NFACE-1:0] cand;
    logic             in_box;
  } item_t;

endpackage

// ===== sv/rbi_div.sv =====
// ----------------------------------------------------------------------------
// rbi_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbi_div (
  input  logic                  clk_i,
  input  logic [rbi_pkg::QW-1:0] num_i,
  input  logic [rbi_pkg::CW-1:0] den_i,
  output logic [rbi_pkg::QW-1:0] quo_o
);
  import rbi_pkg::*;

  logic [CW-1:0] rem [0:QW];
  logic [QW-1:0] nq  [0:QW];
  logic [CW-1:0] den [0:QW];

  assign rem[0] = '0;
  assign nq[0]  = num_i;
  assign den[0] = den_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[s], nq[s][QW-1]};
      diff  = trial - {1'b0, den[s]};
      ge    = trial >= {1'b0, den[s]};
    end

    // numerator bits shift out at the top, quotient bits shift in below
    always_ff @(posedge clk_i) begin
      rem[s+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
      nq[s+1]  <= {nq[s][QW-2:0], ge};
      den[s+1] <= den[s];
    end
  end

  assign quo_o = nq[QW];

endmodule

// ===== sv/rbi_slab.sv =====
// ----------------------------------------------------------------------------
// rbi_slab
// hit point on one other axis and strict slab test, four stages
// ----------------------------------------------------------------------------
module rbi_slab (
  input  logic                   clk_i,
  input  logic [rbi_pkg::QW-1:0] lam_i,
  input  logic [rbi_pkg::CW-1:0] o_i,
  input  logic [rbi_pkg::CW-1:0] d_i,
  input  logic [rbi_pkg::CW-1:0] dmag_i,
  input  logic [rbi_pkg::CW-1:0] lo_i,
  input  logic [rbi_pkg::CW-1:0] hi_i,
  output logic                   in_o
);
  import rbi_pkg::*;

  logic [LSPLIT+CW-1:0] plo_q;
  logic [LHW+CW-1:0]    phi_q;
  logic [MW-1:0]        m_q;
  logic signed [PXW-1:0] p_q;
  logic [1:0]           neg_q;
  logic [1:0][CW-1:0]   o_q;
  logic [2:0][CW-1:0]   lo_q, hi_q;
  logic [PROD_W-1:0]    sum;
  logic [PROD_W-FRAC-1:0] shifted;
  logic [PXW-1:0]       mext;
  logic signed [PXW-1:0] off;

  always_comb begin
    sum     = PROD_W'(plo_q) + (PROD_W'(phi_q) << LSPLIT);
    shifted = sum[PROD_W-1:FRAC];
    mext    = {2'b00, m_q};
    off     = neg_q[1] ? -$signed(mext) : $signed(mext);
  end

  always_ff @(posedge clk_i) begin
    // partial products
    plo_q    <= (LSPLIT+CW)'(lam_i[LSPLIT-1:0]) * (LSPLIT+CW)'(dmag_i);
    phi_q    <= (LHW+CW)'(lam_i[QW-1:LSPLIT]) * (LHW+CW)'(dmag_i);
    neg_q[0] <= d_i[CW-1];
    o_q[0]   <= o_i;
    lo_q[0]  <= lo_i;
    hi_q[0]  <= hi_i;
    // sum, scale and clamp far offsets
    m_q      <= (shifted > (PROD_W-FRAC)'(OFF_SAT)) ? OFF_SAT : shifted[MW-1:0];
    neg_q[1] <= neg_q[0];
    o_q[1]   <= o_q[0];
    lo_q[1]  <= lo_q[0];
    hi_q[1]  <= hi_q[0];
    // hit point
    p_q      <= PXW'($signed(o_q[1])) + off;
    lo_q[2]  <= lo_q[1];
    hi_q[2]  <= hi_q[1];
    // strict inside test
    in_o     <= (PXW'($signed(lo_q[2])) < p_q) && (p_q < PXW'($signed(hi_q[2])));
  end

endmodule

// ===== sv/ray_box_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_box_intersection
// ray against axis-aligned box, nearest face distance, pipelined
// ----------------------------------------------------------------------------
// channel   direction  handshake                 word
// input     in         start / busy              origin, direction, box
// config    in         cfg_valid_i / cfg_ready_o near threshold
// result    out        done_o strobe             hit, inside, distance
//
// one item per cycle; an item passes through entry stages, the 48-stage divider
// (one quotient bit per stage), slab and selection stages. busy never rises
// and the result side has no backpressure. reset clears the valid bits and
// loads the threshold.
// ----------------------------------------------------------------------------
module ray_box_intersection (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [rbi_pkg::CW-1:0] origin_x_i,
  input  logic signed [rbi_pkg::CW-1:0] origin_y_i,
  input  logic signed [rbi_pkg::CW-1:0] origin_z_i,
  input  logic signed [rbi_pkg::CW-1:0] dir_x_i,
  input  logic signed [rbi_pkg::CW-1:0] dir_y_i,
  input  logic signed [rbi_pkg::CW-1:0] dir_z_i,
  input  logic signed [rbi_pkg::CW-1:0] box_lo_x_i,
  input  logic signed [rbi_pkg::CW-1:0] box_lo_y_i,
  input  logic signed [rbi_pkg::CW-1:0] box_lo_z_i,
  input  logic signed [rbi_pkg::CW-1:0] box_hi_x_i,
  input  logic signed [rbi_pkg::CW-1:0] box_hi_y_i,
  input  logic signed [rbi_pkg::CW-1:0] box_hi_z_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rbi_pkg::THR_W-1:0]  cfg_data_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic                       inside_res_o,
  output logic [rbi_pkg::DIST_W-1:0] distance_o
);
  import rbi_pkg::*;

  localparam int DL = QW + 4;

  logic [THR_W-1:0] thr_q;
  logic             s0_v_q, s1_v_q;
  logic [DL-1:0]    dv_q;
  logic             f1_v_q, f2_v_q;
  item_t            s0_q, s1_q, s1_d;
  logic [NFACE-1:0][CW-1:0] s1_num_q, s1_num_d;
  item_t            dl_q [0:DL-1];
  logic [QW-1:0]    quo [NFACE];
  logic [NFACE-1:0][QW-1:0] lam_dl_q [0:3];
  logic [NFACE-1:0][1:0] slab_in;
  logic [NFACE-1:0] acc;
  logic [2:0]       f1_ok_q;
  logic [2:0][QW-1:0] f1_min_q;
  logic             f1_inside_q;
  logic [1:0]       f2_ok_q;
  logic [1:0][QW-1:0] f2_min_q;
  logic             f2_inside_q;
  logic [2:0]       p_ok;
  logic [2:0][QW-1:0] p_min;
  logic             q_ok, r_ok;
  logic [QW-1:0]    q_min, r_min;
  logic             hit_q, inside_q;
  logic [DIST_W-1:0] dist_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // entry stage: per face numerators, candidates, inside test
  always_comb begin
    logic signed [CW:0] num;
    logic signed [CW:0] dx;
    logic               in_box;
    s1_d   = s0_q;
    in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      dx = $signed({s0_q.d[a][CW-1], s0_q.d[a]});
      s1_d.dmag[a] = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      in_box = in_box && ($signed(s0_q.lo[a]) < $signed(s0_q.o[a]))
                      && ($signed(s0_q.o[a]) < $signed(s0_q.hi[a]));
      for (int s = 0; s < 2; s++) begin
        num = (s == 0) ? (CW+1)'($signed(s0_q.lo[a])) - (CW+1)'($signed(s0_q.o[a]))
                       : (CW+1)'($signed(s0_q.hi[a])) - (CW+1)'($signed(s0_q.o[a]));
        s1_d.cand[2*a+s] = (s0_q.d[a] != '0) && (num != '0) &&
                           (num[CW] == s0_q.d[a][CW-1]);
        s1_num_d[2*a+s]  = num[CW] ? CW'(-num) : num[CW-1:0];
      end
    end
    s1_d.in_box = in_box;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      dv_q   <= '0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      s0_v_q <= start && !busy;
      s1_v_q <= s0_v_q;
      dv_q   <= {dv_q[DL-2:0], s1_v_q};
      f1_v_q <= dv_q[DL-1];
      f2_v_q <= f1_v_q;
      done_o <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q.o      <= {origin_z_i, origin_y_i, origin_x_i};
    s0_q.d      <= {dir_z_i, dir_y_i, dir_x_i};
    s0_q.lo     <= {box_lo_z_i, box_lo_y_i, box_lo_x_i};
    s0_q.hi     <= {box_hi_z_i, box_hi_y_i, box_hi_x_i};
    s0_q.dmag   <= '0;
    s0_q.cand   <= '0;
    s0_q.in_box <= 1'b0;
    s1_q        <= s1_d;
    s1_num_q    <= s1_num_d;
    dl_q[0]     <= s1_q;
    for (int k = 1; k < DL; k++) begin
      dl_q[k] <= dl_q[k-1];
    end
    for (int f = 0; f < NFACE; f++) begin
      lam_dl_q[0][f] <= quo[f];
    end
    for (int k = 1; k < 4; k++) begin
      lam_dl_q[k] <= lam_dl_q[k-1];
    end
  end

  for (genvar f = 0; f < NFACE; f++) begin : g_face
    localparam int A = f / 2;
    localparam int B = (A + 1) % 3;
    localparam int C = (A + 2) % 3;

    rbi_div u_div (
      .clk_i (clk_i),
      .num_i ({s1_num_q[f], FRAC'(0)}),
      .den_i (s1_q.dmag[A]),
      .quo_o (quo[f])
    );

    rbi_slab u_slab_b (
      .clk_i  (clk_i),
      .lam_i  (quo[f]),
      .o_i    (dl_q[QW-1].o[B]),
      .d_i    (dl_q[QW-1].d[B]),
      .dmag_i (dl_q[QW-1].dmag[B]),
      .lo_i   (dl_q[QW-1].lo[B]),
      .hi_i   (dl_q[QW-1].hi[B]),
      .in_o   (slab_in[f][0])
    );

    rbi_slab u_slab_c (
      .clk_i  (clk_i),
      .lam_i  (quo[f]),
      .o_i    (dl_q[QW-1].o[C]),
      .d_i    (dl_q[QW-1].d[C]),
      .dmag_i (dl_q[QW-1].dmag[C]),
      .lo_i   (dl_q[QW-1].lo[C]),
      .hi_i   (dl_q[QW-1].hi[C]),
      .in_o   (slab_in[f][1])
    );

    assign acc[f] = dl_q[DL-1].cand[f] && (lam_dl_q[3][f] > QW'(thr_q)) &&
                    slab_in[f][0] && slab_in[f][1];
  end

  // nearest accepted face: pairs, then pair of pairs, then last
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_ok[i]  = acc[2*i] || acc[2*i+1];
      p_min[i] = (acc[2*i] && (!acc[2*i+1] || lam_dl_q[3][2*i] < lam_dl_q[3][2*i+1]))
                 ? lam_dl_q[3][2*i] : lam_dl_q[3][2*i+1];
    end
    q_ok  = f1_ok_q[0] || f1_ok_q[1];
    q_min = (f1_ok_q[0] && (!f1_ok_q[1] || f1_min_q[0] < f1_min_q[1]))
            ? f1_min_q[0] : f1_min_q[1];
    r_ok  = f2_ok_q[0] || f2_ok_q[1];
    r_min = (f2_ok_q[0] && (!f2_ok_q[1] || f2_min_q[0] < f2_min_q[1]))
            ? f2_min_q[0] : f2_min_q[1];
  end

  always_ff @(posedge clk_i) begin
    f1_ok_q     <= p_ok;
    f1_min_q    <= p_min;
    f1_inside_q <= dl_q[DL-1].in_box;
    f2_ok_q     <= {f1_ok_q[2], q_ok};
    f2_min_q    <= {f1_min_q[2], q_min};
    f2_inside_q <= f1_inside_q;
    if (f2_inside_q) begin
      hit_q    <= 1'b1;
      inside_q <= 1'b1;
      dist_q   <= DIST_W'(thr_q);
    end else begin
      hit_q    <= r_ok;
      inside_q <= 1'b0;
      dist_q   <= (r_ok && r_min < QW'(DIST_MAX)) ? r_min[DIST_W-1:0] : DIST_MAX;
    end
  end

  assign hit_o        = hit_q;
  assign inside_res_o = inside_q;
  assign distance_o   = dist_q;

`ifndef SYNTH
  a_inside_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_res_o |-> hit_o)
    else $error("inside result without hit");
  a_miss_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> distance_o == DIST_MAX)
    else $error("miss without saturated distance");
  a_face_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o && !inside_res_o |-> distance_o > DIST_W'(thr_q))
    else $error("face hit not beyond threshold");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// ray against box test: directed and random rays checked against a
// behavioral predictor, with random start gaps and threshold changes
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbi_pkg::*;

  typedef struct {
    logic signed [CW-1:0] o [3];
    logic signed [CW-1:0] d [3];
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
  } ray_t;

  typedef struct {
    logic              hit;
    logic              in_box;
    logic [DIST_W-1:0] dist_val;
  } isect_t;

  localparam int PIPE_LAT = 57;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_o [3];
  logic signed [CW-1:0] in_d [3];
  logic signed [CW-1:0] in_lo [3];
  logic signed [CW-1:0] in_hi [3];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic done_o, hit_o, inside_res_o;
  logic [DIST_W-1:0] distance_o;

  ray_t   ray_q [$];
  isect_t isect_q [$];
  logic [THR_W-1:0] threshold = THR_RESET;
  int fails = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit drained;

  initial begin
    for (int a = 0; a < 3; a++) begin
      in_o[a] = '0; in_d[a] = '0; in_lo[a] = '0; in_hi[a] = '0;
    end
  end

  ray_box_intersection i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .origin_x_i(in_o[0]), .origin_y_i(in_o[1]), .origin_z_i(in_o[2]),
    .dir_x_i(in_d[0]), .dir_y_i(in_d[1]), .dir_z_i(in_d[2]),
    .box_lo_x_i(in_lo[0]), .box_lo_y_i(in_lo[1]), .box_lo_z_i(in_lo[2]),
    .box_hi_x_i(in_hi[0]), .box_hi_y_i(in_hi[1]), .box_hi_z_i(in_hi[2]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .hit_o, .inside_res_o, .distance_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // hit point strictly between the slab faces on another axis
  function automatic bit within_slab(logic signed [63:0] o, logic signed [63:0] d,
                                     logic [63:0] lam, logic signed [63:0] lo,
                                     logic signed [63:0] hi);
    logic [127:0] prod;
    logic [63:0] m;
    logic signed [63:0] p;
    prod = (128'(lam) * 128'(mag(d))) >> 16;
    m = (prod > 128'(64'h4000_0000_0000_0000)) ? 64'h4000_0000_0000_0000 : prod[63:0];
    p = d < 0 ? o - $signed(m) : o + $signed(m);
    return lo < p && p < hi;
  endfunction

  function automatic isect_t predict_isect(ray_t r);
    isect_t res;
    logic signed [63:0] o [3], d [3], lo [3], hi [3];
    logic signed [63:0] num;
    logic [63:0] lam, best;
    bit found;
    int b, c;
    for (int a = 0; a < 3; a++) begin
      o[a] = r.o[a]; d[a] = r.d[a]; lo[a] = r.lo[a]; hi[a] = r.hi[a];
    end
    found = 0; best = '0;
    if (lo[0] < o[0] && o[0] < hi[0] && lo[1] < o[1] && o[1] < hi[1] &&
        lo[2] < o[2] && o[2] < hi[2]) begin
      res.hit = 1'b1; res.in_box = 1'b1; res.dist_val = DIST_W'(threshold);
      return res;
    end
    for (int a = 0; a < 3; a++) begin
      b = (a + 1) % 3; c = (a + 2) % 3;
      if (d[a] == 0) continue;
      for (int f = 0; f < 2; f++) begin
        num = (f == 0 ? lo[a] : hi[a]) - o[a];
        if (num == 0 || ((num < 0) != (d[a] < 0))) continue;
        lam = (mag(num) << 16) / mag(d[a]);
        if (!(lam > 64'(threshold))) continue;
        if (found && !(lam < best)) continue;
        if (within_slab(o[b], d[b], lam, lo[b], hi[b]) &&
            within_slab(o[c], d[c], lam, lo[c], hi[c])) begin
          found = 1; best = lam;
        end
      end
    end
    res.hit = found;
    res.in_box = 1'b0;
    res.dist_val = (found && best < 64'(DIST_MAX)) ? best[DIST_W-1:0] : DIST_MAX;
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return CW'($signed($urandom_range(40 << 16)) - (20 << 16));
      2: return CW'($signed($urandom_range(2000)) - 1000);
      default: return CW'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic ray_t rnd_ray();
    ray_t r;
    logic signed [CW-1:0] t;
    for (int a = 0; a < 3; a++) begin
      r.o[a] = rnd_coord();
      r.d[a] = ($urandom_range(7) == 0) ? '0 : rnd_coord();
      r.lo[a] = rnd_coord();
      r.hi[a] = rnd_coord();
      // mostly well-formed boxes, some inverted or flat
      if ($urandom_range(9) != 0 && r.lo[a] > r.hi[a]) begin
        t = r.lo[a]; r.lo[a] = r.hi[a]; r.hi[a] = t;
      end
      if ($urandom_range(19) == 0) r.hi[a] = r.lo[a];
    end
    // aim some rays at the box
    if ($urandom_range(1) == 0)
      for (int a = 0; a < 3; a++)
        r.d[a] = CW'((r.lo[a] >>> 1) + (r.hi[a] >>> 1) - (r.o[a] >>> 1)
                     + $signed($urandom_range(64)) - 32);
    return r;
  endfunction

  function automatic ray_t mk_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                  logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
    ray_t r;
    for (int a = 0; a < 3; a++) begin
      r.o[a] = o; r.d[a] = d; r.lo[a] = lo; r.hi[a] = hi;
    end
    return r;
  endfunction

  // driver: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && start && !busy) begin
      // previous word taken at the rising edge
    end
    if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (ray_q.size() > 0 && rst_ni) begin
      start <= 1'b1;
      for (int a = 0; a < 3; a++) begin
        in_o[a] <= ray_q[0].o[a]; in_d[a] <= ray_q[0].d[a];
        in_lo[a] <= ray_q[0].lo[a]; in_hi[a] <= ray_q[0].hi[a];
      end
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      isect_q.push_back(predict_isect(ray_q[0]));
      void'(ray_q.pop_front());
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(30);
        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    isect_t exp_r;
    if (rst_ni && done_o) begin
      if (isect_q.size() == 0) begin
        $error("unexpected result word");
        fails++;
      end else begin
        exp_r = isect_q.pop_front();
        if (hit_o !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, hit_o); fails++;
        end
        if (inside_res_o !== exp_r.in_box) begin
          $error("inside_res: expected %0d actual %0d", exp_r.in_box, inside_res_o);
          fails++;
        end
        if (distance_o !== exp_r.dist_val) begin
          $error("distance: expected %0d actual %0d", exp_r.dist_val, distance_o);
          fails++;
        end
      end
    end
  end

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (ray_q.size() > 0 || isect_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  initial begin
    logic [THR_W-1:0] thr_set [5];
    thr_set = '{THR_W'(0), THR_W'(65536), THR_W'(131071), THR_W'(1), THR_W'(66)};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    ray_q.push_back(mk_ray(0, 1 << 16, -(1 << 16), 1 << 16));          // inside
    ray_q.push_back(mk_ray(-(5 << 16), 1 << 16, -(1 << 16), 1 << 16));
    ray_q.push_back(mk_ray(5 << 16, -(1 << 16), -(1 << 16), 1 << 16));
    ray_q.push_back(mk_ray(-(5 << 16), 0, -(1 << 16), 1 << 16));       // zero dir
    ray_q.push_back(mk_ray(-(5 << 16), 1 << 16, 1 << 16, -(1 << 16))); // inverted
    ray_q.push_back(mk_ray(-(5 << 16), 1 << 16, 1 << 16, 1 << 16));    // flat
    ray_q.push_back(mk_ray(32'sh8000_0000, 1, 32'sh8000_0001, 32'sh7fff_ffff));
    ray_q.push_back(mk_ray(32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff));
    ray_q.push_back(mk_ray(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0));
    ray_q.push_back(mk_ray(-1, -1, 32'sh8000_0000, 32'sh7fff_ffff));
    ray_q.push_back(mk_ray(-(1 << 16), 1, 0, 1 << 16));                 // saturating
    ray_q.push_back(mk_ray(-10, 1 << 16, 0, 1 << 16));                  // below threshold
    ray_q.push_back(mk_ray(-1000, 1 << 16, 0, 1 << 16));
    for (int i = 0; i < 8; i++) ray_q.push_back(rnd_ray());
    drain();

    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      for (int i = 0; i < 110; i++) ray_q.push_back(rnd_ray());
      drain();
    end
    write_threshold(THR_W'($urandom_range(65536)));
    for (int i = 0; i < 20; i++) ray_q.push_back(rnd_ray());
    drain();

    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
